/* rtl/lpts_pkg.sv */
// Shared types and constants of the linear probing table store.
// No dependencies; used by the top level through scoped names.
package lpts_pkg;

    localparam int TABLE_SIZE_DEF = 1024;
    localparam int KEY_W          = 63;
    localparam int SLOT_W         = 10;
    localparam int VALUE_W        = 64;
    localparam int STATUS_W       = 2;
    localparam int MAP_WORD_MAX   = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_READ   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RD    = 4'b0100,
        S_CHK   = 4'b1000
    } t_state;

endpackage

/* rtl/lpts_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/linear_probing_table_store_top.sv */
// Top level of the linear probing table store: control, probe scan, result register.
// Depends on lpts_pkg and lpts_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: i_func selects
//   insert (store i_key at the first free slot from key mod TABLE_SIZE upward,
//   wrapping) or read (return the value held in slot key mod TABLE_SIZE, or -1).
//   Output channel (o_out_valid / i_out_ready) returns one result per request:
//   o_status, o_slot and o_read_value, held in an output register.
//   One request is in work at a time. A read passes through the RAM read state
//   and the check state from accept to a valid result. An insert visits k
//   occupancy words (32 slots per word, 1 to TABLE_SIZE/32 + 1); each word
//   costs a bitmap RAM read state plus a check state. An insert into a full
//   table answers from its first check and changes nothing. After reset the
//   occupancy bitmap is cleared one word per cycle with o_in_ready low.
//   A new request is taken while a finished result still waits; a request
//   whose result is ready holds in the check state until the output register
//   is free, so a stalled receiver loses nothing.
module linear_probing_table_store_top #(
    parameter int TABLE_SIZE = lpts_pkg::TABLE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic [lpts_pkg::KEY_W-1:0]   i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lpts_pkg::STATUS_W-1:0] o_status,
    output logic [lpts_pkg::SLOT_W-1:0]  o_slot,
    output logic [lpts_pkg::VALUE_W-1:0] o_read_value
);

    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int WORD_W    = (TABLE_SIZE < lpts_pkg::MAP_WORD_MAX) ? TABLE_SIZE
                                                                     : lpts_pkg::MAP_WORD_MAX;
    localparam int BW        = $clog2(WORD_W);
    localparam int NWORDS    = TABLE_SIZE / WORD_W;
    localparam int MAP_DEPTH = (NWORDS < 2) ? 2 : NWORDS;
    localparam int WAW       = $clog2(MAP_DEPTH);

    lpts_pkg::t_state             r_state, n_state;
    logic                         r_func;
    logic [lpts_pkg::KEY_W-1:0]   r_key;
    logic [AW-1:0]                r_home;
    logic [WAW-1:0]               r_widx, n_widx;
    logic                         r_first, n_first;
    logic [AW:0]                  r_count, n_count;

    logic                         r_out_valid, n_out_valid;
    lpts_pkg::t_status            r_status, n_status;
    logic [lpts_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic [lpts_pkg::VALUE_W-1:0] r_value, n_value;

    logic                         map_we;
    logic [WORD_W-1:0]            map_wdata;
    logic [WORD_W-1:0]            map_rdata;
    logic                         val_we;
    logic [lpts_pkg::KEY_W-1:0]   val_rdata;

    logic                         out_free;
    logic                         in_acc;
    logic                         full;
    logic [WORD_W-1:0]            low_mask;
    logic [WORD_W-1:0]            masked;
    logic [BW-1:0]                fz_idx;
    logic                         found;
    logic [AW-1:0]                found_slot;
    logic [WAW-1:0]               home_widx;
    logic [WAW-1:0]               widx_inc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == lpts_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count == (AW+1)'(TABLE_SIZE));

    assign home_widx  = WAW'({1'b0, i_key[AW-1:0]} >> BW);
    assign widx_inc   = (NWORDS == 1) ? '0 : r_widx + WAW'(1);

    // Bits below the home offset are skipped only in the first word visited.
    assign low_mask   = (WORD_W'(1) << r_home[BW-1:0]) - WORD_W'(1);
    assign masked     = map_rdata | (r_first ? low_mask : '0);

    always_comb begin
        fz_idx = '0;
        found  = 1'b0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!masked[b]) begin
                fz_idx = BW'(b);
                found  = 1'b1;
            end
        end
    end

    assign found_slot = AW'((32'(r_widx) << BW) | 32'(fz_idx));

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_first     = r_first;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_slot      = r_slot;
        n_value     = r_value;
        map_we      = 1'b0;
        map_wdata   = '0;
        val_we      = 1'b0;
        case (r_state)
            lpts_pkg::S_CLEAR: begin
                map_we = 1'b1;
                if (r_widx == WAW'(NWORDS - 1)) begin
                    n_widx  = '0;
                    n_state = lpts_pkg::S_IDLE;
                end else begin
                    n_widx = r_widx + WAW'(1);
                end
            end
            lpts_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_widx  = home_widx;
                    n_first = 1'b1;
                    n_state = lpts_pkg::S_RD;
                end
            end
            lpts_pkg::S_RD: begin
                n_state = lpts_pkg::S_CHK;
            end
            lpts_pkg::S_CHK: begin
                if (out_free) begin
                    if (r_func == lpts_pkg::FUNC_READ) begin
                        n_out_valid = 1'b1;
                        n_status    = lpts_pkg::ST_READ;
                        n_slot      = lpts_pkg::SLOT_W'(32'(r_home));
                        n_value     = map_rdata[r_home[BW-1:0]] ? {1'b0, val_rdata} : '1;
                        n_state     = lpts_pkg::S_IDLE;
                    end else if (full) begin
                        n_out_valid = 1'b1;
                        n_status    = lpts_pkg::ST_FULL;
                        n_slot      = lpts_pkg::SLOT_W'(32'(r_home));
                        n_value     = '0;
                        n_state     = lpts_pkg::S_IDLE;
                    end else if (found) begin
                        map_we      = 1'b1;
                        map_wdata   = map_rdata | (WORD_W'(1) << fz_idx);
                        val_we      = 1'b1;
                        n_count     = r_count + (AW+1)'(1);
                        n_out_valid = 1'b1;
                        n_status    = lpts_pkg::ST_STORED;
                        n_slot      = lpts_pkg::SLOT_W'(32'(found_slot));
                        n_value     = '0;
                        n_state     = lpts_pkg::S_IDLE;
                    end else begin
                        n_widx  = widx_inc;
                        n_first = 1'b0;
                        n_state = lpts_pkg::S_RD;
                    end
                end
            end
            default: begin
                n_state = lpts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpts_pkg::S_CLEAR;
            r_widx      <= '0;
            r_first     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_first     <= n_first;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_home <= i_key[AW-1:0];
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_value  <= n_value;
    end

    lpts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (r_widx),
        .i_wdata (map_wdata),
        .i_raddr (r_widx),
        .o_rdata (map_rdata)
    );

    lpts_ram #(
        .WIDTH (lpts_pkg::KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (found_slot),
        .i_wdata (r_key),
        .i_raddr (r_home),
        .o_rdata (val_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_read_value = r_value;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(TABLE_SIZE))
        else $error("fill count above table size");

    a_accept_starts_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == lpts_pkg::S_RD))
        else $error("accepted request did not start a probe");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (val_we && map_we) |=> (r_count == $past(r_count) + (AW+1)'(1)))
        else $error("stored insert did not bump fill count");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_status == $past(r_status)
                                           && r_slot == $past(r_slot)))
        else $error("pending result overwritten");

endmodule

/* dv/lpts_checker.sv */
// Checker for the linear probing table store: watches the request and result channels, keeps
// its own copy of the table and compares every result. Depends on lpts_pkg.
module lpts_checker
    import lpts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_func,
    input  logic [KEY_W-1:0]    i_key,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VALUE_W-1:0]  i_read_value,
    output int                  o_fail_count,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TABLE_SIZE_DEF;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] read_value;
    } t_answer;

    logic             slot_used [SLOTS];
    logic [KEY_W-1:0] slot_key  [SLOTS];
    int               used_count;
    t_answer          answers_due [$];
    int               mismatches = 0;
    int               due_count  = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = due_count;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (mismatches < 50)
            $display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Applies one request to the local table copy and returns the answer it must give.
    function automatic t_answer table_answer(input logic func, input logic [KEY_W-1:0] key);
        t_answer ans;
        int      home;
        int      pos;
        home           = int'(key % SLOTS);
        ans.slot       = SLOT_W'(home);
        ans.read_value = '0;
        if (func == FUNC_READ) begin
            ans.status     = ST_READ;
            ans.read_value = slot_used[home] ? {1'b0, slot_key[home]} : {VALUE_W{1'b1}};
        end else if (used_count >= SLOTS) begin
            // full table: dropped, nothing changes
            ans.status = ST_FULL;
        end else begin
            pos = home;
            while (slot_used[pos])
                pos = (pos + 1) % SLOTS;
            slot_used[pos] = 1'b1;
            slot_key[pos]  = key;
            used_count++;
            ans.status = ST_STORED;
            ans.slot   = SLOT_W'(pos);
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
            end
            used_count = 0;
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    VALUE_W'(i_status), VALUE_W'(i_slot));
                end else begin
                    want = answers_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", VALUE_W'(i_status),
                                        VALUE_W'(want.status));
                    if (i_slot !== want.slot)
                        report_mismatch("slot", VALUE_W'(i_slot), VALUE_W'(want.slot));
                    if (i_read_value !== want.read_value)
                        report_mismatch("read_value", i_read_value, want.read_value);
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(table_answer(i_func, i_key));
        end
        due_count = answers_due.size();
    end

endmodule

/* dv/tb_linear_probing_table_store_top.sv */
// Testbench top for the linear probing table store: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on lpts_pkg, the RTL top and lpts_checker.
module tb_linear_probing_table_store_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpts_pkg::*;

    localparam int HOME_ANY       = 0;
    localparam int HOME_CLUSTER   = 1;
    localparam int HOME_TOP       = 2;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] ALT_KEY = {53'h15_5555_5555_5555, 10'd512};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_func;
    logic [KEY_W-1:0]    i_key;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [VALUE_W-1:0]  o_read_value;

    int   fail_count;
    int   outstanding;
    int   inserts_sent;
    int   hot_home;
    int   quiet_cycles;
    logic tx_steady;
    logic rx_steady;

    always #6 i_clk = ~i_clk;

    linear_probing_table_store_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_read_value (o_read_value)
    );

    lpts_checker answer_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_slot        (o_slot),
        .i_read_value  (o_read_value),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic func, input logic [KEY_W-1:0] key);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func     = func;
        i_key      = key;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (func == FUNC_INSERT)
            inserts_sent++;
    endtask

    task automatic wait_all_answered();
        i_in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] random_key(input int home_kind);
        logic [KEY_W-SLOT_W-1:0] upper;
        int                      home;
        case ($urandom_range(0, 7))
            0:       upper = '0;
            1:       upper = '1;
            default: upper = (KEY_W-SLOT_W)'({$urandom, $urandom});
        endcase
        case (home_kind)
            HOME_CLUSTER: home = (hot_home + $urandom_range(0, 15)) % TABLE_SIZE_DEF;
            HOME_TOP:     home = $urandom_range(TABLE_SIZE_DEF - 16, TABLE_SIZE_DEF - 1);
            default:      home = $urandom_range(0, TABLE_SIZE_DEF - 1);
        endcase
        return {upper, SLOT_W'(home)};
    endfunction

    // Clustered and top-end homes build long probe runs and wrap-around.
    task automatic send_random(input int insert_pct);
        int   kind;
        logic func;
        kind = $urandom_range(0, 9);
        func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_READ;
        if ($urandom_range(0, 63) == 0)
            hot_home = $urandom_range(0, TABLE_SIZE_DEF - 1);
        send_request(func, random_key(kind < 5 ? HOME_ANY : (kind < 8 ? HOME_CLUSTER : HOME_TOP)));
        if ($urandom_range(0, 149) == 0)
            wait_all_answered();
    endtask

    initial begin
        i_in_valid   = 1'b0;
        i_func       = FUNC_INSERT;
        i_key        = '0;
        i_rst_n      = 1'b0;
        inserts_sent = 0;
        hot_home     = 0;
        tx_steady    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(FUNC_READ, '0);                 // empty slot reads back -1
        send_request(FUNC_READ, KEY_MAX);
        send_request(FUNC_INSERT, '0);
        send_request(FUNC_INSERT, KEY_MAX);          // top slot
        send_request(FUNC_INSERT, 63'd1023);         // wraps past top and slot 0
        send_request(FUNC_READ, 63'd1023);
        send_request(FUNC_READ, 63'd1024);
        send_request(FUNC_READ, 63'd1);
        send_request(FUNC_INSERT, 63'd1);
        send_request(FUNC_INSERT, 63'd1);            // equal keys take separate slots
        send_request(FUNC_INSERT, ALT_KEY);
        send_request(FUNC_INSERT, ~ALT_KEY);
        send_request(FUNC_READ, 63'd512);
        send_request(FUNC_READ, 63'd511);
        send_request(FUNC_READ, 63'd4);
        send_request(FUNC_INSERT, 63'd2053);
        send_request(FUNC_READ, 63'd5);
        send_request(FUNC_READ, 63'd3);

        repeat (900) send_random(50);
        wait_all_answered();
        // keep inserting well past capacity so full-table drops get exercised
        while (inserts_sent < TABLE_SIZE_DEF + 40)
            send_random(80);

        send_request(FUNC_INSERT, '0);
        send_request(FUNC_INSERT, KEY_MAX);
        send_request(FUNC_READ, '0);
        send_request(FUNC_READ, KEY_MAX);
        wait_all_answered();
        repeat (80) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        rx_steady   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            if ($urandom_range(0, 49) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Ends the run when neither channel moves for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/lpts_pkg.sv
rtl/lpts_ram.sv
rtl/linear_probing_table_store_top.sv
dv/lpts_checker.sv
dv/tb_linear_probing_table_store_top.sv
